/* rtl/bocm_pkg.sv */
// Shared constants, codes and operation tables for the 3x3 binary open/close unit.
package bocm_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int NUM_STAGES_DEF = 4;

    // Configuration register indexes
    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    // Mode codes
    localparam logic [2:0] MODE_ERODE      = 3'd0;
    localparam logic [2:0] MODE_DILATE     = 3'd1;
    localparam logic [2:0] MODE_OPEN       = 3'd2;
    localparam logic [2:0] MODE_CLOSE      = 3'd3;
    localparam logic [2:0] MODE_OPEN_CLOSE = 3'd4;

    localparam logic [2:0]  MODE_RESET   = MODE_OPEN;
    localparam logic [10:0] WIDTH_RESET  = 11'd640;
    localparam logic [11:0] HEIGHT_RESET = 12'd480;

    // Number of operations in the sequence of a mode
    function automatic logic [2:0] op_total(input logic [2:0] m);
        logic [2:0] n;
        begin
            case (m)
                MODE_OPEN, MODE_CLOSE: n = 3'd2;
                MODE_OPEN_CLOSE:       n = 3'd4;
                default:               n = 3'd1;
            endcase
            return n;
        end
    endfunction

    // True where stage s of mode m dilates, false where it erodes
    function automatic logic op_is_dilate(input logic [2:0] m, input int s);
        logic d;
        begin
            case (m)
                MODE_DILATE:     d = (s == 0);
                MODE_OPEN:       d = (s == 1);
                MODE_CLOSE:      d = (s == 0);
                MODE_OPEN_CLOSE: d = (s == 1) || (s == 2);
                default:         d = 1'b0;
            endcase
            return d;
        end
    endfunction

endpackage

/* rtl/binary_open_close_3x3_unit.sv */
// Top level of the streaming 3x3 binary erosion/dilation/opening/closing unit.
// One pixel or drain tick is taken per clock unless a result waits on a stalled output;
// each cascaded stage adds a RAM read register, then a window evaluation register, plus a
// delay of image_width+1 pixels, and drain ticks after a frame flush the held pixels.
// Each stage keeps its two previous rows in one RAM of MAX_WIDTH entries of two bits,
// read and written back once per pixel; the single read port per stage sets the rate of
// one item per clock. No clearing pass is needed after reset.
module binary_open_close_3x3_unit #(
    parameter int MAX_WIDTH  = bocm_pkg::MAX_WIDTH_DEF,
    parameter int NUM_STAGES = bocm_pkg::NUM_STAGES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [7:0]  pixel_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  pixel_out,
    output logic        frame_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data
);
    import bocm_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int CW = $clog2(MAX_WIDTH + 3);
    localparam int SW = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;

    logic [2:0]  mode_reg;
    logic [10:0] width_reg;
    logic [11:0] height_reg;
    logic        restart;

    logic [WW-1:0] w_eff;
    logic [11:0]   h_eff;
    logic [2:0]    mode_eff;
    logic [2:0]    n_ops;
    logic [SW-1:0] last_stage;
    logic          adv;

    logic sin_v  [NUM_STAGES];
    logic sin_px [NUM_STAGES];
    logic sin_b  [NUM_STAGES];

    logic link_v_reg    [NUM_STAGES];
    logic link_px_reg   [NUM_STAGES];
    logic link_b_reg    [NUM_STAGES];
    logic link_last_reg [NUM_STAGES];

    // Configuration registers; a valid write to the mode, width or height register restarts the stages
    assign cfg_ready = 1'b1;
    assign restart   = cfg_valid && (cfg_index == REG_MODE || cfg_index == REG_WIDTH ||
                                     cfg_index == REG_HEIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_RESET;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MODE:   mode_reg   <= cfg_data[2:0];
                REG_WIDTH:  width_reg  <= cfg_data[10:0];
                REG_HEIGHT: height_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Clamp geometry and decode the mode
    always_comb
    begin
        if (width_reg < 11'd3)
            w_eff = WW'(3);
        else if (32'(width_reg) > MAX_WIDTH)
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(width_reg);
        h_eff    = (height_reg < 12'd3) ? 12'd3 : height_reg;
        mode_eff = (mode_reg <= MODE_OPEN_CLOSE) ? mode_reg : MODE_OPEN;
        n_ops    = op_total(mode_eff);
        if (32'(n_ops) > NUM_STAGES)
            last_stage = SW'(NUM_STAGES - 1);
        else
            last_stage = SW'(n_ops - 3'd1);
    end

    // Whole pipeline advances unless a result waits on a stalled output
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    assign sin_v[0]  = in_valid;
    assign sin_px[0] = !func;
    assign sin_b[0]  = (pixel_in != 8'd0);

    genvar s;
    generate
        for (s = 0; s < NUM_STAGES; s++)
        begin : g_stage
            logic [11:0]   in_row_reg, out_row_reg;
            logic [WW-1:0] in_col_reg, out_col_reg;
            logic [AW-1:0] ptr_reg;
            logic [CW-1:0] pend_reg;

            logic          e_v_reg, e_px_reg, e_emit_reg, e_border_reg, e_last_reg;
            logic          e_b_reg, e_hi_reg;
            logic [AW-1:0] e_addr_reg;
            logic          fwd_v_reg;
            logic [1:0]    fwd_d_reg;
            logic          bot1_reg, bot2_reg, mid1_reg, mid2_reg, top1_reg, top2_reg;

            logic          go, pend_full, emit, border, last_px, dilate;
            logic [WW-1:0] wm1;
            logic [CW-1:0] wp1;
            logic [AW-1:0] rd_addr, drain_addr, ptr_inc;
            logic          wr_en;
            logic [1:0]    wr_data, ram_q, rd_d;
            logic [8:0]    win;
            logic          head, res;

            if (s > 0)
            begin : g_link
                assign sin_v[s]  = link_v_reg[s-1];
                assign sin_px[s] = link_px_reg[s-1];
                assign sin_b[s]  = link_b_reg[s-1];
            end

            // Decide emission and the read address for this event
            always_comb
            begin
                go        = sin_v[s] && adv;
                wm1       = w_eff - WW'(1);
                wp1       = CW'(w_eff) + CW'(1);
                pend_full = (pend_reg == wp1);
                if (sin_px[s])
                    emit = pend_full;
                else
                    emit = (pend_reg != '0) && (in_row_reg == 12'd0) && (in_col_reg == '0);
                if (pend_full)
                    drain_addr = (ptr_reg == '0) ? AW'(wm1) : ptr_reg - AW'(1);
                else if (CW'(ptr_reg) >= pend_reg)
                    drain_addr = AW'(CW'(ptr_reg) - pend_reg);
                else
                    drain_addr = AW'(CW'(ptr_reg) + CW'(w_eff) - pend_reg);
                rd_addr = sin_px[s] ? ptr_reg : drain_addr;
                ptr_inc = (WW'(ptr_reg) == wm1) ? '0 : ptr_reg + AW'(1);
                border  = (out_row_reg == 12'd0) || (out_row_reg == h_eff - 12'd1) ||
                          (out_col_reg == '0) || (out_col_reg == wm1);
                last_px = (out_row_reg == h_eff - 12'd1) && (out_col_reg == wm1);
                dilate  = op_is_dilate(mode_eff, s);
            end

            // Write back the shifted rows; forward when a read hits the same entry
            assign wr_en   = e_v_reg && e_px_reg && adv;
            assign rd_d    = fwd_v_reg ? fwd_d_reg : ram_q;
            assign wr_data = {rd_d[0], e_b_reg};

            bocm_ram #(
                .WIDTH (2),
                .DEPTH (MAX_WIDTH)
            ) u_line (
                .clk   (clk),
                .we    (wr_en),
                .waddr (e_addr_reg),
                .wdata (wr_data),
                .re    (go),
                .raddr (rd_addr),
                .rdata (ram_q)
            );

            // Evaluate the window
            always_comb
            begin
                win  = {top2_reg, top1_reg, rd_d[1], mid2_reg, mid1_reg, rd_d[0],
                        bot2_reg, bot1_reg, e_b_reg};
                head = e_px_reg ? mid1_reg : (e_hi_reg ? rd_d[1] : rd_d[0]);
                if (e_border_reg)
                    res = head;
                else if (dilate)
                    res = |win;
                else
                    res = &win;
            end

            // Advance position counters
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    in_row_reg  <= '0;
                    in_col_reg  <= '0;
                    out_row_reg <= '0;
                    out_col_reg <= '0;
                    ptr_reg     <= '0;
                    pend_reg    <= '0;
                end
                else if (restart)
                begin
                    in_row_reg  <= '0;
                    in_col_reg  <= '0;
                    out_row_reg <= '0;
                    out_col_reg <= '0;
                    ptr_reg     <= '0;
                    pend_reg    <= '0;
                end
                else if (go)
                begin
                    if (sin_px[s])
                    begin
                        ptr_reg <= ptr_inc;
                        if (in_col_reg == wm1)
                        begin
                            in_col_reg <= '0;
                            in_row_reg <= (in_row_reg == h_eff - 12'd1) ? 12'd0
                                                                        : in_row_reg + 12'd1;
                        end
                        else
                        begin
                            in_col_reg <= in_col_reg + WW'(1);
                        end
                        if (!emit)
                            pend_reg <= pend_reg + CW'(1);
                    end
                    else if (emit)
                    begin
                        pend_reg <= pend_reg - CW'(1);
                    end
                    if (emit)
                    begin
                        if (out_col_reg == wm1)
                        begin
                            out_col_reg <= '0;
                            out_row_reg <= (out_row_reg == h_eff - 12'd1) ? 12'd0
                                                                          : out_row_reg + 12'd1;
                        end
                        else
                        begin
                            out_col_reg <= out_col_reg + WW'(1);
                        end
                    end
                end
            end

            // Hold event control between read and evaluation
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    e_v_reg          <= 1'b0;
                    fwd_v_reg        <= 1'b0;
                    link_v_reg[s]    <= 1'b0;
                    link_px_reg[s]   <= 1'b0;
                end
                else if (adv)
                begin
                    e_v_reg        <= go;
                    fwd_v_reg      <= go && wr_en && (e_addr_reg == rd_addr);
                    link_v_reg[s]  <= e_v_reg;
                    link_px_reg[s] <= e_v_reg && e_emit_reg;
                end
            end

            // Event payload, forwarded data and window columns
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    e_px_reg          <= sin_px[s];
                    e_emit_reg        <= emit;
                    e_border_reg      <= border;
                    e_last_reg        <= last_px;
                    e_b_reg           <= sin_b[s];
                    e_hi_reg          <= !sin_px[s] && pend_full;
                    e_addr_reg        <= rd_addr;
                    fwd_d_reg         <= wr_data;
                    link_b_reg[s]     <= res;
                    link_last_reg[s]  <= e_last_reg;
                end
                if (wr_en)
                begin
                    bot1_reg <= e_b_reg;
                    bot2_reg <= bot1_reg;
                    mid1_reg <= rd_d[0];
                    mid2_reg <= mid1_reg;
                    top1_reg <= rd_d[1];
                    top2_reg <= top1_reg;
                end
            end
        end
    endgenerate

    // Drive the result from the last active stage
    assign out_valid  = link_v_reg[last_stage] && link_px_reg[last_stage];
    assign pixel_out  = link_b_reg[last_stage] ? 8'd255 : 8'd0;
    assign frame_last = link_last_reg[last_stage];

endmodule

/* rtl/bocm_ram.sv */
// Generic simple dual-port RAM with registered read.
module bocm_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* tb/sv/bocm_tb_pkg.sv */
// Item codes shared by the open/close testbench files.
`timescale 1ns / 1ps
package bocm_tb_pkg;

    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_DRAIN = 1'b1;

    // Index outside the register list: the write is ignored
    localparam logic [1:0] REG_UNUSED = 2'd3;

endpackage

/* tb/sv/bocm_checker.sv */
// Checker for the open/close unit: watches all channels, predicts output pixels, compares.
`timescale 1ns / 1ps
module bocm_checker
    import bocm_pkg::*;
    import bocm_tb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        func,
    input  logic [7:0]  pixel_in,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  pixel_out,
    input  logic        frame_last,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data,
    output int          fail_count,
    output int          pixels_waiting,
    output int          pixels_seen
);

    localparam int MAXW = MAX_WIDTH_DEF;
    localparam int HIST = 2 * MAXW + 8;
    localparam int STAGES = NUM_STAGES_DEF;

    typedef struct {
        logic [7:0] pix;
        logic       last;
    } out_pixel_t;

    out_pixel_t pixel_fifo[$];

    logic [2:0]  cur_mode;
    logic [10:0] cur_width;
    logic [11:0] cur_height;

    bit          row_hist[STAGES][HIST];
    int unsigned in_row[STAGES], in_col[STAGES], out_row[STAGES], out_col[STAGES];
    int unsigned wr_slot[STAGES], held[STAGES];

    // Clear every stage position; history bits stay
    function automatic void restart_all();
        for (int s = 0; s < STAGES; s++)
        begin
            in_row[s] = 0; in_col[s] = 0; out_row[s] = 0; out_col[s] = 0;
            wr_slot[s] = 0; held[s] = 0;
        end
    endfunction

    // Stage s of mode m: 1 dilates, 0 erodes
    function automatic bit stage_dilates(logic [2:0] m, int s);
        case (m)
            MODE_ERODE:      return 1'b0;
            MODE_DILATE:     return s == 0;
            MODE_CLOSE:      return s == 0;
            MODE_OPEN_CLOSE: return s == 1 || s == 2;
            default:         return s == 1;
        endcase
    endfunction

    function automatic int stage_count(logic [2:0] m);
        int n;
        case (m)
            MODE_ERODE, MODE_DILATE: n = 1;
            MODE_OPEN_CLOSE:         n = 4;
            default:                 n = 2;
        endcase
        return n > STAGES ? STAGES : n;
    endfunction

    // Advance one stage by one event; returns 1 when it emits a pixel
    function automatic bit morph_stage(int s, bit is_pix, bit pix, bit dil, int unsigned w,
                                       int unsigned h, output bit res, output bit last);
        bit          fire;
        int unsigned o, idx;
        bit          all_set, any_set;
        res = 0;
        last = 0;
        if (is_pix)
        begin
            row_hist[s][wr_slot[s]] = pix;
            wr_slot[s] = (wr_slot[s] + 1) % HIST;
            held[s]++;
            in_col[s]++;
            if (in_col[s] >= w)
            begin
                in_col[s] = 0;
                in_row[s]++;
                if (in_row[s] >= h)
                    in_row[s] = 0;
            end
            fire = held[s] > w + 1;
        end
        else
            fire = held[s] > 0 && in_row[s] == 0 && in_col[s] == 0;
        if (!fire)
            return 0;
        o = (wr_slot[s] + HIST - held[s]) % HIST;
        all_set = 1;
        any_set = 0;
        for (int dr = -1; dr <= 1; dr++)
            for (int dc = -1; dc <= 1; dc++)
            begin
                idx = (o + HIST + dr * int'(w) + dc) % HIST;
                all_set &= row_hist[s][idx];
                any_set |= row_hist[s][idx];
            end
        if (out_row[s] == 0 || out_row[s] == h - 1 || out_col[s] == 0 || out_col[s] == w - 1)
            res = row_hist[s][o];
        else
            res = dil ? any_set : all_set;
        last = out_row[s] == h - 1 && out_col[s] == w - 1;
        out_col[s]++;
        if (out_col[s] >= w)
        begin
            out_col[s] = 0;
            out_row[s]++;
            if (out_row[s] >= h)
                out_row[s] = 0;
        end
        held[s]--;
        return 1;
    endfunction

    // Run an accepted item through the enabled stages
    function automatic void predict_item(logic f, logic [7:0] p);
        int unsigned w, h;
        bit          live, b, lst, ob, ol;
        logic [2:0]  m;
        out_pixel_t  e;
        w = cur_width < 3 ? 3 : (cur_width > MAXW ? MAXW : cur_width);
        h = cur_height < 3 ? 3 : cur_height;
        m = cur_mode > MODE_OPEN_CLOSE ? MODE_OPEN : cur_mode;
        live = f == FUNC_PIXEL;
        b = p != 0;
        lst = 0;
        for (int s = 0; s < stage_count(m); s++)
        begin
            live = morph_stage(s, live, b, stage_dilates(m, s), w, h, ob, ol);
            b = ob;
            lst = ol;
        end
        if (live)
        begin
            e.pix = b ? 8'd255 : 8'd0;
            e.last = lst;
            pixel_fifo.push_back(e);
        end
    endfunction

    initial
    begin
        cur_mode = MODE_RESET;
        cur_width = WIDTH_RESET;
        cur_height = HEIGHT_RESET;
        restart_all();
        fail_count = 0;
        pixels_seen = 0;
        pixels_waiting = 0;
    end

    always @(posedge clk)
    begin
        out_pixel_t e;
        if (rst_n)
        begin
            // Register write restarts the stages
            if (cfg_valid && cfg_ready && cfg_index != REG_UNUSED)
            begin
                case (cfg_index)
                    REG_MODE:  cur_mode = cfg_data[2:0];
                    REG_WIDTH: cur_width = cfg_data[10:0];
                    default:   cur_height = cfg_data;
                endcase
                restart_all();
            end
            if (in_valid && !in_stall)
                predict_item(func, pixel_in);
            // Compare an output transfer with the oldest prediction
            if (out_valid && !out_stall)
            begin
                pixels_seen++;
                if (pixel_fifo.size() == 0)
                begin
                    $error("unexpected output transfer: pixel_out %0d frame_last %0d",
                           pixel_out, frame_last);
                    fail_count++;
                end
                else
                begin
                    e = pixel_fifo.pop_front();
                    if (pixel_out !== e.pix)
                    begin
                        $error("pixel_out expected %0d actual %0d", e.pix, pixel_out);
                        fail_count++;
                    end
                    if (frame_last !== e.last)
                    begin
                        $error("frame_last expected %0d actual %0d", e.last, frame_last);
                        fail_count++;
                    end
                end
            end
            pixels_waiting = pixel_fifo.size();
        end
    end

endmodule

/* tb/sv/tb_binary_open_close_3x3_unit.sv */
// Top of the open/close unit testbench: clock, reset, stimulus, stall pattern and verdict.
`timescale 1ns / 1ps
module tb_binary_open_close_3x3_unit;
    import bocm_pkg::*;
    import bocm_tb_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        func;
    logic [7:0]  pixel_in;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  pixel_out;
    logic        frame_last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [11:0] cfg_data;

    int fail_count, pixels_waiting, pixels_seen;
    int cycle_count;
    int burst_left;
    int frames_sent;
    int stall_style;
    int active_width;
    int active_stages;

    binary_open_close_3x3_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .func(func), .pixel_in(pixel_in),
        .out_valid(out_valid), .out_stall(out_stall),
        .pixel_out(pixel_out), .frame_last(frame_last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    bocm_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .func(func), .pixel_in(pixel_in),
        .out_valid(out_valid), .out_stall(out_stall),
        .pixel_out(pixel_out), .frame_last(frame_last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pixels_waiting(pixels_waiting),
        .pixels_seen(pixels_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_binary_open_close_3x3_unit NOT OK");
            $finish;
        end
    end

    // Receiver stall: switch between random stall styles
    always @(posedge clk)
    begin
        if (cycle_count % 300 == 0)
            stall_style <= $urandom_range(0, 3);
        case (stall_style)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 9) < 3);
            2:       out_stall <= (cycle_count % 7) < 2;
            default: out_stall <= ($urandom_range(0, 9) < 7);
        endcase
    end

    // Hold one item until it transfers; end bursts with a random gap
    task automatic send_item(logic f, logic [7:0] p);
        in_valid <= 1'b1;
        func <= f;
        pixel_in <= p;
        do
            @(posedge clk);
        while (in_stall);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(0, 12);
        end
    endtask

    task automatic write_reg(logic [1:0] idx, logic [11:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Drop valid, let all predicted pixels arrive, then let the pipeline settle
    task automatic wait_quiet();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pixels_waiting != 0)
            @(posedge clk);
        repeat (24) @(posedge clk);
    endtask

    task automatic set_phase(logic [2:0] m, logic [10:0] w, logic [11:0] h);
        wait_quiet();
        write_reg(REG_MODE, {9'd0, m});
        write_reg(REG_WIDTH, {1'b0, w});
        write_reg(REG_HEIGHT, h);
        active_width = w < 3 ? 3 : (w > MAX_WIDTH_DEF ? MAX_WIDTH_DEF : w);
        case (m)
            MODE_ERODE, MODE_DILATE: active_stages = 1;
            MODE_OPEN_CLOSE:         active_stages = 4;
            default:                 active_stages = 2;
        endcase
    endtask

    // Random pixel: foreground with chance dens in 16, any nonzero value
    function automatic logic [7:0] rand_pixel(int dens);
        if ($urandom_range(0, 15) < dens)
            return 8'($urandom_range(1, 255));
        return 8'd0;
    endfunction

    // Flush what the stages still hold after a frame
    task automatic drain_all();
        repeat (active_stages * (active_width + 2) + 2)
            send_item(FUNC_DRAIN, 8'($urandom_range(0, 255)));
    endtask

    // One frame in raster order, with stray drain ticks now and then
    task automatic send_frame(int w, int h, int dens);
        for (int i = 0; i < w * h; i++)
        begin
            if ($urandom_range(0, 40) == 0)
                send_item(FUNC_DRAIN, 8'($urandom_range(0, 255)));
            send_item(FUNC_PIXEL, rand_pixel(dens));
        end
        frames_sent++;
    endtask

    initial
    begin
        logic [7:0] corner_px[9];
        int         w, h;
        int         mr;
        cycle_count = 0;
        burst_left = 0;
        frames_sent = 0;
        stall_style = 0;
        active_width = 640;
        active_stages = 2;
        rst_n = 1'b0;
        in_valid = 1'b0;
        func = FUNC_PIXEL;
        pixel_in = 8'd0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_MODE;
        cfg_data = 12'd0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Ten pixels at the reset geometry, then a write to the unused index, which is ignored
        repeat (10) send_item(FUNC_PIXEL, rand_pixel(8));
        wait_quiet();
        write_reg(REG_UNUSED, 12'hFFF);

        // Smallest frame, edge pixel values, centre decided by the window
        corner_px = '{8'h80, 8'h01, 8'h7F, 8'hFE, 8'hFF, 8'h01, 8'h80, 8'hFE, 8'h7F};
        set_phase(MODE_ERODE, 11'd3, 12'd3);
        foreach (corner_px[i])
            send_item(FUNC_PIXEL, corner_px[i]);
        drain_all();
        set_phase(MODE_DILATE, 11'd3, 12'd3);
        for (int i = 0; i < 9; i++)
            send_item(FUNC_PIXEL, i == 0 ? 8'h01 : 8'h00);
        drain_all();

        // Every mode including unused codes, small geometries, random content
        for (int m = 0; m < 8; m++)
        begin
            w = $urandom_range(3, 5);
            h = $urandom_range(3, 4);
            set_phase(m[2:0], w[10:0], h[11:0]);
            repeat ($urandom_range(1, 2))
            begin
                send_frame(w, h, $urandom_range(2, 15));
                if ($urandom_range(0, 3) == 0)
                    drain_all();
            end
            drain_all();
        end

        // Out-of-range geometry clamps
        set_phase(MODE_OPEN_CLOSE, 11'd0, 12'd0);
        send_frame(3, 3, 12);
        drain_all();
        set_phase(MODE_CLOSE, 11'd2, 12'd2);
        send_frame(3, 3, 6);
        drain_all();
        set_phase(MODE_OPEN, 11'd4, 12'd1);
        send_frame(4, 3, 10);
        drain_all();

        // Partial frame abandoned by a register write
        set_phase(MODE_OPEN, 11'd5, 12'd4);
        repeat (11) send_item(FUNC_PIXEL, rand_pixel(10));
        set_phase(MODE_OPEN, 11'd5, 12'd4);
        send_frame(5, 4, 11);
        drain_all();

        // Random part: small frames, mostly well formed
        for (int k = 0; k < 2; k++)
        begin
            w = $urandom_range(3, 8);
            h = $urandom_range(3, 5);
            mr = $urandom_range(0, 4);
            set_phase(mr[2:0], w[10:0], h[11:0]);
            repeat ($urandom_range(1, 2))
                send_frame(w, h, $urandom_range(1, 15));
            drain_all();
        end

        // Wait out the tail with a bound
        in_valid <= 1'b0;
        while (pixels_waiting != 0 && cycle_count < CYCLE_LIMIT - 100)
            @(posedge clk);
        repeat (30) @(posedge clk);
        $display("frames sent: %0d, output pixels checked: %0d, %0d left unmatched",
                 frames_sent, pixels_seen, pixels_waiting);
        if (fail_count == 0 && pixels_waiting == 0)
            $display("tb_binary_open_close_3x3_unit OK");
        else
            $display("tb_binary_open_close_3x3_unit NOT OK");
        $finish;
    end

endmodule
